// ----- hw/rtl/tcw_pkg.sv -----
// Shared constants, request codes and types of the text console writer.
`default_nettype none

package tcw_pkg;

    // Default geometry
    localparam int CELLS_DEF    = 2048;
    localparam int COLUMNS_DEF  = 80;
    localparam int CONSOLES_DEF = 8;

    // Port field widths
    localparam int TYPE_W  = 3;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 4;
    localparam int SEL_W   = 3;
    localparam int IDX_W   = 11;
    localparam int POS_W   = 11;
    localparam int CELL_W  = 16;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 11;

    // Request codes
    localparam logic [TYPE_W-1:0] REQ_WRITE     = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_WRITE_COL = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_CLEAR     = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_CLEAR_BG  = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_SELECT    = 3'd4;
    localparam logic [TYPE_W-1:0] REQ_READ      = 3'd5;

    // Control characters
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;

    localparam int TAB_STEP = 4;

    // Default colours
    localparam logic [COLOR_W-1:0] DEF_FG = 4'hF;
    localparam logic [COLOR_W-1:0] DEF_BG = 4'h0;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_CLAMP   = 2'd1;
    localparam logic [STAT_W-1:0] ST_REFUSED = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LE_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LE_START  = 1'd1;

    // One captured request
    typedef struct packed {
        logic [TYPE_W-1:0]  req_type;
        logic [CHAR_W-1:0]  char_code;
        logic [COLOR_W-1:0] fg_color;
        logic [COLOR_W-1:0] bg_color;
        logic [SEL_W-1:0]   console_sel;
        logic [IDX_W-1:0]   cell_index;
    } req_t;

    // Cursor table update commands from the sequencer
    typedef struct packed {
        logic put;
        logic clear;
        logic select;
    } cmd_t;

    // Outcome of a character request
    typedef struct packed {
        logic              wr_en;
        logic [STAT_W-1:0] status;
    } plan_t;

    function automatic logic [CELL_W-1:0] make_cell(
        input logic [CHAR_W-1:0]  ch,
        input logic [COLOR_W-1:0] fg,
        input logic [COLOR_W-1:0] bg
    );
        return {bg, fg, ch};
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tcw_cell_mem.sv -----
// Single-port-write, registered-read cell store of all consoles.
`default_nettype none

module tcw_cell_mem
    import tcw_pkg::*;
#(
    parameter int ADDR_W = 14,
    parameter int DEPTH  = 16384
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [CELL_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [CELL_W-1:0] rdata
);

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, hold data until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/tcw_cursor.sv -----
// Cursor and column tables, active console and character request planning.
`default_nettype none

module tcw_cursor
    import tcw_pkg::*;
#(
    parameter int CELLS    = CELLS_DEF,
    parameter int COLUMNS  = COLUMNS_DEF,
    parameter int CONSOLES = CONSOLES_DEF,
    localparam int CUR_W   = $clog2(CELLS),
    localparam int CON_W   = (CONSOLES > 1) ? $clog2(CONSOLES) : 1
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire req_t                  req,
    input  wire logic                  le_enable,
    input  wire logic [CFG_DATA_W-1:0] le_start,
    input  wire cmd_t                  cmd,
    output plan_t                      plan,
    output logic      [CUR_W-1:0]      wr_cell,
    output logic      [CELL_W-1:0]     wr_data,
    output logic      [CON_W-1:0]      active,
    output logic      [CUR_W-1:0]      post_pos
);

    localparam int COL_W = $clog2(COLUMNS);
    localparam logic [CUR_W-1:0] LAST_CELL = CUR_W'(CELLS - 1);
    localparam logic [CUR_W:0]   LAST_EXT  = (CUR_W+1)'(CELLS - 1);
    localparam logic [COL_W-1:0] CLAMP_COL = COL_W'((CELLS - 1) % COLUMNS);
    localparam logic [COL_W-1:0] COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [COL_W:0]   COL_END   = (COL_W+1)'(COLUMNS);

    logic [CUR_W-1:0] cur_tab_reg [CONSOLES];
    logic [COL_W-1:0] col_tab_reg [CONSOLES];
    logic [CON_W-1:0] act_reg;

    logic [CUR_W-1:0] pos;
    logic [COL_W-1:0] col;
    logic             use_def;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    logic             is_nl;
    logic             is_tab;
    logic             is_bs;
    logic [CUR_W:0]   tgt;
    logic             clamp;
    logic [COL_W:0]   col4;
    logic [COL_W:0]   col1;
    logic [COL_W-1:0] col_step;
    logic [CUR_W-1:0] bs_pos;
    logic [COL_W-1:0] bs_col;
    logic             refused;
    logic [CUR_W-1:0] put_pos;
    logic [COL_W-1:0] put_col;
    logic [31:0]      sel32;
    logic             sel_ok;

    assign pos     = cur_tab_reg[act_reg];
    assign col     = col_tab_reg[act_reg];
    assign use_def = (req.req_type == REQ_WRITE);
    assign fg      = use_def ? DEF_FG : req.fg_color;
    assign bg      = use_def ? DEF_BG : req.bg_color;
    assign is_nl   = (req.char_code == CH_NEWLINE);
    assign is_tab  = (req.char_code == CH_TAB);
    assign is_bs   = (req.char_code == CH_BACKSPACE);

    // Target of a forward move; the column keeps pos mod COLUMNS
    always_comb
    begin
        if (is_nl)
        begin
            tgt = {1'b0, pos} - (CUR_W+1)'(col) + (CUR_W+1)'(COLUMNS);
        end
        else if (is_tab)
        begin
            tgt = {1'b0, pos} + (CUR_W+1)'(TAB_STEP);
        end
        else
        begin
            tgt = {1'b0, pos} + (CUR_W+1)'(1);
        end
    end

    assign clamp = (tgt > LAST_EXT);

    // Column after a forward move, wrapped once
    assign col4 = {1'b0, col} + (COL_W+1)'(TAB_STEP);
    assign col1 = {1'b0, col} + (COL_W+1)'(1);

    always_comb
    begin
        if (is_nl)
        begin
            col_step = '0;
        end
        else if (is_tab)
        begin
            col_step = (col4 >= COL_END) ? COL_W'(col4 - COL_END) : col4[COL_W-1:0];
        end
        else
        begin
            col_step = (col1 == COL_END) ? '0 : col1[COL_W-1:0];
        end
    end

    // Backspace step and the line edit guard
    assign bs_pos  = pos - CUR_W'(1);
    assign bs_col  = (col == '0) ? COL_LAST : col - COL_W'(1);
    assign refused = (pos == '0) ||
                     (use_def && le_enable && (32'(bs_pos) < 32'(le_start)));

    // Plan the cell write, status and new cursor
    always_comb
    begin
        if (is_bs)
        begin
            plan.wr_en  = !refused;
            plan.status = refused ? ST_REFUSED : ST_OK;
            put_pos     = refused ? pos : bs_pos;
            put_col     = refused ? col : bs_col;
        end
        else
        begin
            plan.wr_en  = !(is_nl || is_tab);
            plan.status = clamp ? ST_CLAMP : ST_OK;
            put_pos     = clamp ? LAST_CELL : tgt[CUR_W-1:0];
            put_col     = clamp ? CLAMP_COL : col_step;
        end
    end

    assign wr_cell = is_bs ? bs_pos : pos;
    assign wr_data = make_cell(is_bs ? '0 : req.char_code, fg, bg);

    assign sel32  = 32'(req.console_sel);
    assign sel_ok = (sel32 < 32'(CONSOLES));

    // Update the tables and the active console
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= '0;
            for (int i = 0; i < CONSOLES; i++)
            begin
                cur_tab_reg[i] <= '0;
                col_tab_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.put)
            begin
                cur_tab_reg[act_reg] <= put_pos;
                col_tab_reg[act_reg] <= put_col;
            end
            if (cmd.clear)
            begin
                cur_tab_reg[act_reg] <= '0;
                col_tab_reg[act_reg] <= '0;
            end
            if (cmd.select && sel_ok)
            begin
                act_reg <= sel32[CON_W-1:0];
            end
        end
    end

    assign active   = act_reg;
    assign post_pos = cmd.put ? put_pos : (cmd.clear ? '0 : pos);

endmodule

`default_nettype wire

// ----- hw/rtl/text_console_writer_unit.sv -----
// Top level of the text console writer: sequencer, configuration and result register.
`default_nettype none

// Text console writer. Holds CONSOLES text consoles of CELLS 16-bit cells
// (char | fg<<8 | bg<<12) in one registered-read memory, plus a cursor per
// console. Requests are taken one at a time. A character write, newline, tab
// or backspace is captured, then, once the result register is free, does at
// most one memory write and a cursor update; select and read load their result
// from a later state (the memory read is registered). A clear writes one cell a
// cycle. After reset the block sweeps all CONSOLES*2**clog2(CELLS) cells of the
// memory to zero (16384 at the default size) and holds req_stall high until the
// sweep ends. The result register lets the next request be captured while a
// result waits; configuration writes are always ready.

module text_console_writer_unit
    import tcw_pkg::*;
#(
    parameter int CELLS    = CELLS_DEF,
    parameter int COLUMNS  = COLUMNS_DEF,
    parameter int CONSOLES = CONSOLES_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Request channel
    input  wire logic                  req_valid,
    output logic                       req_stall,
    input  wire logic [TYPE_W-1:0]     req_type,
    input  wire logic [CHAR_W-1:0]     char_code,
    input  wire logic [COLOR_W-1:0]    fg_color,
    input  wire logic [COLOR_W-1:0]    bg_color,
    input  wire logic [SEL_W-1:0]      console_sel,
    input  wire logic [IDX_W-1:0]      cell_index,
    // Result channel
    output logic                       rsp_valid,
    input  wire logic                  rsp_stall,
    output logic      [POS_W-1:0]      cursor_pos,
    output logic      [CELL_W-1:0]     cell_value,
    output logic      [SEL_W-1:0]      active_console,
    output logic      [STAT_W-1:0]     status,
    // Configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CUR_W     = $clog2(CELLS);
    localparam int CON_W     = (CONSOLES > 1) ? $clog2(CONSOLES) : 1;
    localparam int MEM_DEPTH = CONSOLES * (2 ** CUR_W);
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MEM_DEPTH - 1);
    localparam logic [CUR_W-1:0]  LAST_CELL = CUR_W'(CELLS - 1);

    // Sequencer states
    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_CLEAR  = 3'd3;
    localparam logic [2:0] S_RESP   = 3'd4;
    localparam logic [2:0] S_RDWAIT = 3'd5;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [ADDR_W-1:0] cnt_reg;
    logic [ADDR_W-1:0] cnt_next;
    req_t              req_reg;
    logic              le_enable_reg;
    logic [CFG_DATA_W-1:0] le_start_reg;

    logic              rsp_valid_reg;
    logic [POS_W-1:0]  rsp_pos_reg;
    logic [CELL_W-1:0] rsp_val_reg;
    logic [SEL_W-1:0]  rsp_act_reg;
    logic [STAT_W-1:0] rsp_st_reg;

    logic              rsp_load;
    logic [CELL_W-1:0] rsp_val_next;
    logic [STAT_W-1:0] rsp_st_next;
    logic              rsp_free;

    cmd_t              cmd;
    plan_t             plan;
    logic [CUR_W-1:0]  wr_cell;
    logic [CELL_W-1:0] wr_data;
    logic [CON_W-1:0]  active;
    logic [CUR_W-1:0]  post_pos;
    logic [31:0]       post_pos32;
    logic [31:0]       active32;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CELL_W-1:0] mem_rdata;
    logic              read_hit;
    logic [COLOR_W-1:0] clear_bg;

    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [CON_W-1:0] con,
        input logic [CUR_W-1:0] slot
    );
        logic [31:0] full;
        full = (32'(con) << CUR_W) | 32'(slot);
        return full[ADDR_W-1:0];
    endfunction

    tcw_cell_mem #(
        .ADDR_W (ADDR_W),
        .DEPTH  (MEM_DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tcw_cursor #(
        .CELLS    (CELLS),
        .COLUMNS  (COLUMNS),
        .CONSOLES (CONSOLES)
    ) u_cursor (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_reg),
        .le_enable (le_enable_reg),
        .le_start  (le_start_reg),
        .cmd       (cmd),
        .plan      (plan),
        .wr_cell   (wr_cell),
        .wr_data   (wr_data),
        .active    (active),
        .post_pos  (post_pos)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign read_hit  = (32'(req_reg.cell_index) < 32'(CELLS));
    assign clear_bg  = (req_reg.req_type == REQ_CLEAR_BG) ? req_reg.bg_color : DEF_BG;

    // Sequence the request through memory and cursor tables
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        mem_we       = 1'b0;
        mem_waddr    = cell_addr(active, wr_cell);
        mem_wdata    = wr_data;
        mem_re       = 1'b0;
        mem_raddr    = cell_addr(active, CUR_W'(req_reg.cell_index));
        rsp_load     = 1'b0;
        rsp_val_next = '0;
        rsp_st_next  = ST_OK;
        case (state_reg)
            S_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = '0;
                if (cnt_reg == LAST_ADDR)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (rsp_free)
                begin
                    case (req_reg.req_type)
                        REQ_WRITE, REQ_WRITE_COL:
                        begin
                            cmd.put     = 1'b1;
                            mem_we      = plan.wr_en;
                            rsp_load    = 1'b1;
                            rsp_st_next = plan.status;
                            state_next  = S_IDLE;
                        end
                        REQ_CLEAR, REQ_CLEAR_BG:
                        begin
                            cnt_next   = '0;
                            state_next = S_CLEAR;
                        end
                        REQ_SELECT:
                        begin
                            cmd.select = 1'b1;
                            state_next = S_RESP;
                        end
                        REQ_READ:
                        begin
                            mem_re     = 1'b1;
                            state_next = S_RDWAIT;
                        end
                        default:
                        begin
                            rsp_load   = 1'b1;
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cell_addr(active, cnt_reg[CUR_W-1:0]);
                mem_wdata = make_cell('0, DEF_FG, clear_bg);
                if (cnt_reg[CUR_W-1:0] == LAST_CELL)
                begin
                    cmd.clear  = 1'b1;
                    rsp_load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end
            S_RESP:
            begin
                rsp_load   = 1'b1;
                state_next = S_IDLE;
            end
            S_RDWAIT:
            begin
                rsp_load     = 1'b1;
                rsp_val_next = read_hit ? mem_rdata : '0;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Advance the sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Capture the accepted request
    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            req_reg.req_type    <= req_type;
            req_reg.char_code   <= char_code;
            req_reg.fg_color    <= fg_color;
            req_reg.bg_color    <= bg_color;
            req_reg.console_sel <= console_sel;
            req_reg.cell_index  <= cell_index;
        end
    end

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            le_enable_reg <= 1'b0;
            le_start_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LE_ENABLE: le_enable_reg <= cfg_data[0];
                CFG_LE_START:  le_start_reg  <= cfg_data;
                default:       le_enable_reg <= le_enable_reg;
            endcase
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (rsp_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    assign post_pos32 = 32'(post_pos);
    assign active32   = 32'(active);

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_pos_reg <= post_pos32[POS_W-1:0];
            rsp_val_reg <= rsp_val_next;
            rsp_act_reg <= active32[SEL_W-1:0];
            rsp_st_reg  <= rsp_st_next;
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign cursor_pos     = rsp_pos_reg;
    assign cell_value     = rsp_val_reg;
    assign active_console = rsp_act_reg;
    assign status         = rsp_st_reg;

endmodule

`default_nettype wire

// ----- test/text_console_writer_check.sv -----
// Checker for the text console writer: predicts every result and compares it on the result channel.
`timescale 1ns / 100ps

module text_console_writer_check
    import tcw_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    input  wire logic                  req_stall,
    input  wire logic [TYPE_W-1:0]     req_type,
    input  wire logic [CHAR_W-1:0]     char_code,
    input  wire logic [COLOR_W-1:0]    fg_color,
    input  wire logic [COLOR_W-1:0]    bg_color,
    input  wire logic [SEL_W-1:0]      console_sel,
    input  wire logic [IDX_W-1:0]      cell_index,
    input  wire logic                  rsp_valid,
    input  wire logic                  rsp_stall,
    input  wire logic [POS_W-1:0]      cursor_pos,
    input  wire logic [CELL_W-1:0]     cell_value,
    input  wire logic [SEL_W-1:0]      active_console,
    input  wire logic [STAT_W-1:0]     status,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int                         fail_count,
    output int                         outstanding,
    output int                         results_checked,
    output int                         clamp_count,
    output int                         refusal_count
);

    localparam int STORE_DEPTH = CONSOLES_DEF * CELLS_DEF;

    // What the block should return for one request
    typedef struct packed {
        logic [POS_W-1:0]  cursor;
        logic [CELL_W-1:0] cell_word;
        logic [SEL_W-1:0]  console;
        logic [STAT_W-1:0] status;
    } console_view_t;

    // Shadow copy of the consoles and of the line-edit registers
    logic [CELL_W-1:0] screen_cells [STORE_DEPTH];
    logic [POS_W-1:0]  cursor_of [CONSOLES_DEF];
    logic [SEL_W-1:0]  shown_console;
    logic              edit_guard_on;
    logic [IDX_W-1:0]  edit_start;

    console_view_t expected_views [$];
    int mismatches;
    int compared;
    int clamps;
    int refusals;

    assign fail_count      = mismatches;
    assign results_checked = compared;
    assign clamp_count     = clamps;
    assign refusal_count   = refusals;

    // Move the active cursor, saturating at the last cell
    function automatic logic [STAT_W-1:0] place_cursor(input int target);
        if (target > CELLS_DEF - 1)
        begin
            cursor_of[shown_console] = POS_W'(CELLS_DEF - 1);
            return ST_CLAMP;
        end
        cursor_of[shown_console] = POS_W'(target);
        return ST_OK;
    endfunction

    // Character, newline, tab or backspace on the active console
    function automatic logic [STAT_W-1:0] put_character(
        input logic [CHAR_W-1:0]  ch,
        input logic [COLOR_W-1:0] fg,
        input logic [COLOR_W-1:0] bg,
        input bit                 guarded
    );
        int pos;
        int base;
        pos  = int'(cursor_of[shown_console]);
        base = int'(shown_console) * CELLS_DEF;
        case (ch)
            CH_NEWLINE:
                return place_cursor((pos / COLUMNS_DEF) * COLUMNS_DEF + COLUMNS_DEF);
            CH_TAB:
                return place_cursor(pos + TAB_STEP);
            CH_BACKSPACE:
            begin
                if (pos == 0)
                    return ST_REFUSED;
                // the default-colour backspace stops at the editable line start
                if (guarded && edit_guard_on && (pos - 1) < int'(edit_start))
                    return ST_REFUSED;
                screen_cells[base + pos - 1] = {bg, fg, CHAR_W'(0)};
                cursor_of[shown_console] = POS_W'(pos - 1);
                return ST_OK;
            end
            default:
            begin
                screen_cells[base + pos] = {bg, fg, ch};
                return place_cursor(pos + 1);
            end
        endcase
    endfunction

    // Fill the active console with blanks and home the cursor
    function automatic void wipe_console(input logic [COLOR_W-1:0] bg);
        int base;
        base = int'(shown_console) * CELLS_DEF;
        for (int i = 0; i < CELLS_DEF; i++)
            screen_cells[base + i] = {bg, DEF_FG, CHAR_W'(0)};
        cursor_of[shown_console] = '0;
    endfunction

    // Apply one request to the shadow state and form its result
    function automatic console_view_t apply_request(
        input logic [TYPE_W-1:0]  kind,
        input logic [CHAR_W-1:0]  ch,
        input logic [COLOR_W-1:0] fg,
        input logic [COLOR_W-1:0] bg,
        input logic [SEL_W-1:0]   sel,
        input logic [IDX_W-1:0]   idx
    );
        console_view_t view;
        view.cell_word = '0;
        view.status    = ST_OK;
        case (kind)
            REQ_WRITE:     view.status = put_character(ch, DEF_FG, DEF_BG, 1'b1);
            REQ_WRITE_COL: view.status = put_character(ch, fg, bg, 1'b0);
            REQ_CLEAR:     wipe_console(DEF_BG);
            REQ_CLEAR_BG:  wipe_console(bg);
            REQ_SELECT:
                if (int'(sel) < CONSOLES_DEF)
                    shown_console = sel;
            REQ_READ:
                if (int'(idx) < CELLS_DEF)
                    view.cell_word = screen_cells[int'(shown_console) * CELLS_DEF + int'(idx)];
            default: ;
        endcase
        view.cursor  = cursor_of[shown_console];
        view.console = shown_console;
        return view;
    endfunction

    function automatic void compare_field(
        input string       field_name,
        input logic [31:0] want_value,
        input logic [31:0] got_value
    );
        if (got_value !== want_value)
        begin
            $error("%s: expected %0d, actual %0d", field_name, want_value, got_value);
            mismatches++;
        end
    endfunction

    // Watch the three channels: registers, results, then new requests
    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        console_view_t want;
        if (!rst_n)
        begin
            foreach (screen_cells[i])
                screen_cells[i] = '0;
            foreach (cursor_of[i])
                cursor_of[i] = '0;
            shown_console = '0;
            edit_guard_on = 1'b0;
            edit_start    = '0;
            expected_views.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_LE_ENABLE)
                    edit_guard_on = cfg_data[0];
                else if (cfg_index == CFG_LE_START)
                    edit_start = cfg_data[IDX_W-1:0];
            end

            if (rsp_valid && !rsp_stall)
            begin
                if (expected_views.size() == 0)
                begin
                    $error("result with no request waiting: cursor %0d cell %0h console %0d status %0d",
                           cursor_pos, cell_value, active_console, status);
                    mismatches++;
                end
                else
                begin
                    want = expected_views.pop_front();
                    compare_field("cursor_pos", 32'(want.cursor), 32'(cursor_pos));
                    compare_field("cell_value", 32'(want.cell_word), 32'(cell_value));
                    compare_field("active_console", 32'(want.console), 32'(active_console));
                    compare_field("status", 32'(want.status), 32'(status));
                    compared++;
                end
            end

            if (req_valid && !req_stall)
            begin
                want = apply_request(req_type, char_code, fg_color, bg_color,
                                     console_sel, cell_index);
                if (want.status == ST_CLAMP)
                    clamps++;
                if (want.status == ST_REFUSED)
                    refusals++;
                expected_views.push_back(want);
            end

            outstanding <= expected_views.size();
        end
    end

endmodule

// ----- test/text_console_writer_unit_test.sv -----
// Testbench top for the text console writer: stimulus, receiver stalls and the verdict.
`timescale 1ns / 100ps

module text_console_writer_unit_test;
    import tcw_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 5;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_ITEMS = 1050;
    localparam int PHASES       = 5;
    localparam int TAIL_ITEMS   = 120;
    localparam int DRAIN_CYCLES = 20;

    // Request codes the block leaves unused
    localparam logic [TYPE_W-1:0] REQ_SPARE_LO = 3'd6;
    localparam logic [TYPE_W-1:0] REQ_SPARE_HI = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  req_valid;
    logic                  req_stall;
    req_t                  req_bus;
    logic                  rsp_valid;
    logic                  rsp_stall;
    logic [POS_W-1:0]      cursor_pos;
    logic [CELL_W-1:0]     cell_value;
    logic [SEL_W-1:0]      active_console;
    logic [STAT_W-1:0]     status;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int outstanding;
    int results_checked;
    int clamp_count;
    int refusal_count;

    int cycle_count;
    int requests_sent;
    int settings_used;
    bit sender_gaps;
    bit calm_tail;
    bit hold_off_req;

    always #(CLK_PERIOD / 2) clk = ~clk;

    text_console_writer_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req_type       (req_bus.req_type),
        .char_code      (req_bus.char_code),
        .fg_color       (req_bus.fg_color),
        .bg_color       (req_bus.bg_color),
        .console_sel    (req_bus.console_sel),
        .cell_index     (req_bus.cell_index),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .cursor_pos     (cursor_pos),
        .cell_value     (cell_value),
        .active_console (active_console),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    text_console_writer_check i_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .req_type        (req_bus.req_type),
        .char_code       (req_bus.char_code),
        .fg_color        (req_bus.fg_color),
        .bg_color        (req_bus.bg_color),
        .console_sel     (req_bus.console_sel),
        .cell_index      (req_bus.cell_index),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .cursor_pos      (cursor_pos),
        .cell_value      (cell_value),
        .active_console  (active_console),
        .status          (status),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .clamp_count     (clamp_count),
        .refusal_count   (refusal_count)
    );

    // Request with every field random, unused code points included
    function automatic req_t random_request();
        req_t r;
        r.req_type    = TYPE_W'($urandom_range(0, 7));
        r.char_code   = CHAR_W'($urandom_range(0, 255));
        r.fg_color    = COLOR_W'($urandom_range(0, 15));
        r.bg_color    = COLOR_W'($urandom_range(0, 15));
        r.console_sel = SEL_W'($urandom_range(0, 7));
        r.cell_index  = IDX_W'($urandom_range(0, 2047));
        return r;
    endfunction

    // Mostly printable text, now and then any byte
    function automatic logic [CHAR_W-1:0] typed_char();
        if ($urandom_range(0, 9) < 7)
            return CHAR_W'($urandom_range(32, 126));
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    function automatic req_t char_request(input bit coloured, input logic [CHAR_W-1:0] ch);
        req_t r;
        r = random_request();
        r.req_type  = coloured ? REQ_WRITE_COL : REQ_WRITE;
        r.char_code = ch;
        return r;
    endfunction

    function automatic req_t kind_request(input logic [TYPE_W-1:0] kind);
        req_t r;
        r = random_request();
        r.req_type = kind;
        return r;
    endfunction

    function automatic req_t read_request(input logic [IDX_W-1:0] idx);
        req_t r;
        r = kind_request(REQ_READ);
        r.cell_index = idx;
        return r;
    endfunction

    // Offer one request, with an optional idle gap first, and hold it until taken
    task automatic issue(input req_t item);
        if (sender_gaps && !calm_tail && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_bus   <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        requests_sent++;
    endtask

    // Stop offering and wait for every outstanding result
    task automatic wait_drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Write both line-edit registers; the block must be idle
    task automatic program_line_edit(input logic enable, input logic [IDX_W-1:0] start);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_LE_ENABLE;
        cfg_data  <= CFG_DATA_W'(enable);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= CFG_LE_START;
        cfg_data  <= CFG_DATA_W'(start);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // One burst of related requests, shaped like real console traffic
    task automatic run_burst();
        req_t r;
        int   pick;
        pick = $urandom_range(0, 99);
        sender_gaps = ($urandom_range(0, 2) != 0);
        if (pick < 45)
        begin
            // type a line of text
            repeat ($urandom_range(4, 40))
                issue(char_request($urandom_range(0, 1) == 1, typed_char()));
        end
        else if (pick < 53)
        begin
            // run the cursor off the end of the buffer
            repeat ($urandom_range(20, 30))
                issue(char_request($urandom_range(0, 1) == 1,
                                   ($urandom_range(0, 3) == 0) ? CH_TAB : CH_NEWLINE));
            repeat ($urandom_range(1, 4))
                issue(char_request($urandom_range(0, 1) == 1, typed_char()));
        end
        else if (pick < 68)
        begin
            // type a little, then erase back past the edit start
            repeat ($urandom_range(0, 6))
                issue(char_request(1'b0, typed_char()));
            repeat ($urandom_range(3, 20))
                issue(char_request($urandom_range(0, 4) == 0, CH_BACKSPACE));
        end
        else if (pick < 80)
        begin
            // read back, mostly near the start of the screen
            repeat ($urandom_range(1, 10))
            begin
                r = kind_request(REQ_READ);
                if ($urandom_range(0, 1) == 1)
                    r.cell_index = IDX_W'($urandom_range(0, 200));
                issue(r);
            end
        end
        else if (pick < 88)
            issue(kind_request(REQ_SELECT));
        else if (pick < 94)
            issue(kind_request(($urandom_range(0, 1) == 1) ? REQ_CLEAR : REQ_CLEAR_BG));
        else
        begin
            repeat ($urandom_range(1, 4))
                issue(random_request());
        end
    endtask

    // Receiver: random stall bursts in noisy stretches, one long hold-off on request
    initial
    begin
        bit receiver_noisy;
        bit held_off;
        int stretch_left;
        rsp_stall <= 1'b0;
        receiver_noisy = 1'b1;
        held_off       = 1'b0;
        stretch_left   = 200;
        forever
        begin
            @(posedge clk);
            if (stretch_left == 0)
            begin
                receiver_noisy = ($urandom_range(0, 1) == 1);
                stretch_left   = $urandom_range(50, 400);
            end
            else
                stretch_left--;
            if (hold_off_req && !held_off)
            begin
                rsp_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                rsp_stall <= 1'b0;
                held_off = 1'b1;
            end
            else if (receiver_noisy && !calm_tail && $urandom_range(0, 7) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    // Bound the run
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, outstanding);
        $display("Verification failed");
        $finish;
    end

    // Main stimulus
    initial
    begin
        req_t r;
        int   phase_end;
        int   random_target;
        logic phase_enable [PHASES];
        logic [IDX_W-1:0] phase_start [PHASES];

        req_valid <= 1'b0;
        req_bus   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        requests_sent = 0;
        settings_used = 0;
        sender_gaps   = 1'b1;
        calm_tail     = 1'b0;
        hold_off_req  = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, every request kind, the special cases
        program_line_edit(1'b0, '0);
        issue(read_request('1));
        issue(char_request(1'b0, 8'h41));
        r = char_request(1'b1, 8'hFF);
        r.fg_color = '1;
        r.bg_color = '1;
        issue(r);
        r = char_request(1'b1, 8'h00);
        r.fg_color = '0;
        r.bg_color = '0;
        issue(r);
        issue(char_request(1'b0, CH_TAB));
        issue(char_request(1'b1, CH_NEWLINE));
        issue(char_request(1'b0, CH_BACKSPACE));
        issue(read_request(11'd0));
        issue(read_request(11'd1));
        issue(read_request(11'd79));
        issue(kind_request(REQ_SPARE_LO));
        issue(kind_request(REQ_SPARE_HI));
        r = kind_request(REQ_SELECT);
        r.console_sel = '1;
        issue(r);
        // backspace on an empty console, both colour forms
        issue(char_request(1'b0, CH_BACKSPACE));
        issue(char_request(1'b1, CH_BACKSPACE));
        r = kind_request(REQ_CLEAR_BG);
        r.bg_color = '1;
        issue(r);
        issue(read_request('1));
        issue(kind_request(REQ_CLEAR));
        issue(read_request('1));
        r = kind_request(REQ_SELECT);
        r.console_sel = '0;
        issue(r);
        // line-edit boundary: the default backspace is refused, the coloured one is not
        wait_drain();
        program_line_edit(1'b1, '1);
        issue(char_request(1'b0, CH_BACKSPACE));
        issue(char_request(1'b1, CH_BACKSPACE));

        // Random phases, each under its own line-edit setting
        phase_enable[0] = 1'b0; phase_start[0] = IDX_W'($urandom_range(0, 2047));
        phase_enable[1] = 1'b1; phase_start[1] = IDX_W'($urandom_range(40, 300));
        phase_enable[2] = 1'b1; phase_start[2] = '0;
        phase_enable[3] = 1'b1; phase_start[3] = IDX_W'($urandom_range(1024, 2047));
        phase_enable[4] = 1'b0; phase_start[4] = '1;
        random_target = requests_sent + RANDOM_ITEMS;
        for (int p = 0; p < PHASES; p++)
        begin
            wait_drain();
            program_line_edit(phase_enable[p], phase_start[p]);
            // fill the block against a stalled receiver
            if (p == 1)
                hold_off_req = 1'b1;
            phase_end = requests_sent + RANDOM_ITEMS / PHASES;
            while (requests_sent < phase_end)
            begin
                calm_tail = (requests_sent >= random_target - TAIL_ITEMS);
                run_burst();
            end
        end

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests and compared %0d results: %0d cursor clamps, %0d refusals",
                 requests_sent, results_checked, clamp_count, refusal_count);
        $display("Line-edit settings applied: %0d, cycles run: %0d", settings_used, cycle_count);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_cell_mem.sv
hw/rtl/tcw_cursor.sv
hw/rtl/text_console_writer_unit.sv
test/text_console_writer_check.sv
test/text_console_writer_unit_test.sv
